>>> hw/rtl/hsm_pkg.sv
// Shared constants and control types for the hashed set block.
package hsm_pkg;

   localparam int KEY_W       = 32;
   localparam int KIND_W      = 2;
   localparam int BUCKETS     = 1024;
   localparam int WAYS        = 4;
   localparam int BUCKET_BITS = $clog2(BUCKETS);
   localparam int ROW_W       = WAYS * (KEY_W + 1);

   // Golden-ratio fraction (sqrt(5)-1)/2 in unsigned 0.32 fixed point
   localparam logic [KEY_W-1:0] GOLDEN_FRAC = 32'h9E37_79B9;

   // Operation codes carried in the request kind field; the spare code acts as a lookup
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

   typedef struct packed {
      logic clear;   // write one zeroed row of the clearing sweep
      logic load;    // capture the request beat and its bucket
      logic read;    // issue the bucket row read
      logic commit;  // write the row back and launch the response beat
   } hsm_cmd_type;

   typedef struct packed {
      logic clear_last;  // sweep is at the final row
      logic out_busy;    // response register holds a beat that is not being taken
   } hsm_sts_type;

endpackage

>>> hw/rtl/hash_set_membership.sv
// Top level of the hashed set membership block.
//
// Request channel (req_): one beat per operation. req_tuser carries the kind
// (insert, delete, lookup; the spare code acts as a lookup) and req_tdata the
// signed 32-bit key. Response channel (rsp_): one beat per request, with
// found (key present before the operation) and overflow (insert dropped, bucket full).
// Keys live in a 1024-bucket, 4-way row RAM; the bucket is the top bits of the
// fractional product of |key| and the golden-ratio fraction.
// Timing: a request is taken in the idle state, its bucket row is read in the
// read state, and matched and written back in the match state, when the response beat is
// launched. No new request is taken until the last one is written back, set by the single row RAM
// (read, then write-back) and the hash register in front of it.
// Reset: synchronous, active high. After reset a clearing sweep zeroes the
// valid bits one row a cycle, all 1024 rows, with req_tready low.
// Stall: the response register holds its beat while rsp_tready is low; the
// next request is still taken and read, but its write-back waits until the
// held beat is taken.
module hash_set_membership import hsm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // [31:0] key
   input  logic [1:0]        req_tuser,   // [1:0] kind
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata    // [0] found, [1] overflow, [7:2] zero
);

   hsm_cmd_type cmd;
   hsm_sts_type sts;
   logic        found;
   logic        overflow;

   // Sequencer: owns the request handshake
   hsm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath: hash, row store, compare and response register
   hsm_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_kind     (req_tuser),
      .req_key      (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_found    (found),
      .rsp_overflow (overflow)
   );

   // Pack the response beat, lowest field first
   assign rsp_tdata = {6'b0, overflow, found};

endmodule

>>> hw/rtl/hsm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module hsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/hsm_ctrl.sv
// Sequencer for the hashed set: clearing sweep, then load, read and commit per beat.
module hsm_ctrl import hsm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  hsm_sts_type sts,
   output hsm_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_MATCH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_MATCH;
         end
         ST_MATCH: begin
            // hold the read row until the response register is free
            if (!sts.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/hsm_dp.sv
// Datapath of the hashed set: hash, bucket row store, way match and response register.
module hsm_dp import hsm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  hsm_cmd_type         cmd,
   output hsm_sts_type         sts,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [KEY_W-1:0]    req_key,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic                rsp_found,
   output logic                rsp_overflow
);

   logic [KIND_W-1:0]      kind_ff;
   logic [KEY_W-1:0]       key_ff;
   logic [BUCKET_BITS-1:0] bucket_ff, bucket_in;
   logic [BUCKET_BITS-1:0] clr_cnt_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   found_ff, overflow_ff;

   logic [KEY_W-1:0]       mag;
   logic [2*KEY_W-1:0]     prod;
   logic [KEY_W-1:0]       frac;

   logic [ROW_W-1:0]       row_rd, row_wr, ram_wdata;
   logic [BUCKET_BITS-1:0] ram_waddr;
   logic                   ram_we;
   logic [WAYS-1:0]        valid_vec, hit_vec, free_vec, hit_sel, free_sel;
   logic                   found, any_free, is_insert, is_delete, overflow;

   // Multiplicative hash of the key's magnitude; bucket is the top bits of the fraction
   assign mag       = req_key[KEY_W-1] ? (KEY_W'(0) - req_key) : req_key;
   assign prod      = (2*KEY_W)'(mag) * (2*KEY_W)'(GOLDEN_FRAC);
   assign frac      = prod[KEY_W-1:0];
   assign bucket_in = frac[KEY_W-1 -: BUCKET_BITS];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         key_ff    <= req_key;
         bucket_ff <= bucket_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_ff + BUCKET_BITS'(1);
      end
   end

   assign sts.clear_last = &clr_cnt_ff;
   assign sts.out_busy   = rsp_valid_ff && !rsp_tready;

   // Way compare on the registered row
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         valid_vec[w] = row_rd[WAYS*KEY_W + w];
         hit_vec[w]   = valid_vec[w] && (row_rd[w*KEY_W +: KEY_W] == key_ff);
         free_vec[w]  = !valid_vec[w];
      end
   end

   assign hit_sel   = hit_vec & ~(hit_vec - WAYS'(1));
   assign free_sel  = free_vec & ~(free_vec - WAYS'(1));
   assign found     = |hit_vec;
   assign any_free  = |free_vec;
   assign is_insert = (kind_ff == KIND_INSERT);
   assign is_delete = (kind_ff == KIND_DELETE);
   assign overflow  = is_insert && !found && !any_free;

   always_comb begin
      row_wr = row_rd;
      for (int w = 0; w < WAYS; w++) begin
         if (is_insert && !found && free_sel[w]) begin
            row_wr[w*KEY_W +: KEY_W]  = key_ff;
            row_wr[WAYS*KEY_W + w]    = 1'b1;
         end
         if (is_delete && hit_sel[w]) begin
            row_wr[WAYS*KEY_W + w]    = 1'b0;
         end
      end
   end

   assign ram_we    = cmd.clear || cmd.commit;
   assign ram_waddr = cmd.clear ? clr_cnt_ff : bucket_ff;
   assign ram_wdata = cmd.clear ? '0 : row_wr;

   hsm_ram #(
      .WIDTH (ROW_W),
      .DEPTH (BUCKETS)
   ) u_row_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.read),
      .raddr (bucket_ff),
      .rdata (row_rd)
   );

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         found_ff    <= found;
         overflow_ff <= overflow;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_found    = found_ff;
   assign rsp_overflow = overflow_ff;

`ifndef ASSERT_OFF
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && !rsp_tready))
      else $error("commit while response register stalled");

   a_commit_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not launch a response beat");

   a_clear_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !(cmd.load || cmd.read || cmd.commit))
      else $error("item activity during clearing sweep");

   a_ovf_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(found_ff && overflow_ff))
      else $error("overflow flagged for a present key");
`endif

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the hashed set membership block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hsm_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;   // spare code, behaves as a lookup
   localparam int SLOTS        = BUCKETS * WAYS;
   localparam int IDLE_MAX     = 10;
   localparam int FAIL_REPORTS = 10;
   localparam int POOL_KEEP    = 75;                   // percent of keys drawn from the pool

   typedef struct packed {
      logic found;
      logic overflow;
   } member_result_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata  = '0;   // [31:0] key
   logic [1:0]        req_tuser  = '0;   // [1:0] kind
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;         // [0] found, [1] overflow, [7:2] zero

   // Shadow copy of the set
   logic [KEY_W-1:0]  shadow_keys  [SLOTS];
   bit                shadow_valid [SLOTS];

   member_result_type results_due [$];
   logic [KEY_W-1:0]  bucket_mates [$];
   logic [KEY_W-1:0]  key_pool [$];
   int                failures = 0;
   bit                calm     = 1'b0;   // both sides run without idling while set

   hash_set_membership i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("hash_set_membership verification failed");
      $finish;
   end

   // Multiplicative hash: top bits of the fractional product of |key| and the golden fraction
   function automatic logic [BUCKET_BITS-1:0] bucket_index(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] mag;
      logic [KEY_W-1:0] frac;
      mag  = key[KEY_W-1] ? (~key + 1'b1) : key;
      frac = mag * GOLDEN_FRAC;
      return frac[KEY_W-1 -: BUCKET_BITS];
   endfunction

   // Apply one operation to the shadow set and return what the block should answer
   function automatic member_result_type apply_to_set(input logic [KIND_W-1:0] kind,
                                                      input logic [KEY_W-1:0]  key);
      int                base;
      int                hit;
      int                free_way;
      member_result_type res;
      base     = int'(bucket_index(key)) * WAYS;
      hit      = -1;
      free_way = -1;
      for (int w = 0; w < WAYS; w++) begin
         if (shadow_valid[base + w]) begin
            if (hit < 0 && shadow_keys[base + w] == key) hit = w;
         end else if (free_way < 0) begin
            free_way = w;
         end
      end
      res.found    = (hit >= 0);
      res.overflow = 1'b0;
      case (kind)
         KIND_INSERT: begin
            if (hit < 0) begin
               if (free_way >= 0) begin
                  shadow_keys[base + free_way]  = key;
                  shadow_valid[base + free_way] = 1'b1;
               end else begin
                  res.overflow = 1'b1;
               end
            end
         end
         KIND_DELETE: begin
            if (hit >= 0) shadow_valid[base + hit] = 1'b0;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Gather keys that share a bucket with the anchor
   function automatic void collect_mates(input logic [KEY_W-1:0] anchor, input int count);
      logic [KEY_W-1:0] cand;
      bucket_mates.delete();
      cand = anchor;
      while (bucket_mates.size() < count) begin
         cand = cand + 1'b1;
         if (bucket_index(cand) == bucket_index(anchor)) bucket_mates.push_back(cand);
      end
   endfunction

   // Send one request beat; leave tvalid high only when the next beat follows at once
   task automatic send_op(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= key;
      do @(posedge clock); while (!req_tready);
      results_due.push_back(apply_to_set(kind, key));
      gap = calm ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off the sender until every outstanding response has been taken
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_due.size() != 0);
   endtask

   function automatic logic [KIND_W-1:0] pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return KIND_INSERT;
      if (r < 65) return KIND_DELETE;
      if (r < 95) return KIND_LOOKUP;
      return KIND_SPARE;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      if (key_pool.size() != 0 && $urandom_range(0, 99) < POOL_KEEP)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      return $urandom();
   endfunction

   task automatic random_ops(input int count);
      repeat (count) send_op(pick_kind(), pick_key());
   endtask

   // Build a pool of keys crowded into a few buckets so that hits and full buckets occur
   task automatic build_key_pool();
      logic [KEY_W-1:0] anchor;
      key_pool.delete();
      repeat (4) begin
         anchor = $urandom();
         key_pool.push_back(anchor);
         key_pool.push_back(~anchor + 1'b1);
         collect_mates(anchor, 6);
         foreach (bucket_mates[i]) key_pool.push_back(bucket_mates[i]);
      end
      repeat (16) key_pool.push_back($urandom());
      key_pool.push_back(32'h0000_0000);
      key_pool.push_back(32'h8000_0000);
      key_pool.push_back(32'h7FFF_FFFF);
      key_pool.push_back(32'hFFFF_FFFF);
   endtask

   // Extremes, repeated and absent keys, the spare code and a full bucket
   task automatic test_directed();
      logic [KEY_W-1:0] anchor;
      anchor = 32'd12345;
      send_op(KIND_LOOKUP, 32'h0000_0000);
      send_op(KIND_INSERT, 32'h0000_0000);
      send_op(KIND_INSERT, 32'h0000_0000);   // already present
      send_op(KIND_LOOKUP, 32'h0000_0000);
      send_op(KIND_DELETE, 32'h0000_0000);
      send_op(KIND_DELETE, 32'h0000_0000);   // already gone
      send_op(KIND_INSERT, 32'h8000_0000);   // most negative key
      send_op(KIND_SPARE,  32'h8000_0000);
      send_op(KIND_INSERT, 32'h7FFF_FFFF);
      send_op(KIND_INSERT, 32'h8000_0001);   // same magnitude, same bucket
      send_op(KIND_LOOKUP, 32'h8000_0001);
      send_op(KIND_INSERT, 32'hFFFF_FFFF);
      send_op(KIND_LOOKUP, 32'h0000_0001);
      collect_mates(anchor, 4);
      send_op(KIND_INSERT, anchor);
      for (int i = 0; i < 3; i++) send_op(KIND_INSERT, bucket_mates[i]);
      send_op(KIND_INSERT, bucket_mates[3]);  // bucket full, dropped
      send_op(KIND_INSERT, bucket_mates[0]);  // present key in a full bucket
      send_op(KIND_LOOKUP, bucket_mates[3]);
      send_op(KIND_DELETE, bucket_mates[1]);
      send_op(KIND_INSERT, bucket_mates[3]);  // lands in the freed way
      send_op(KIND_LOOKUP, bucket_mates[3]);
      send_op(KIND_DELETE, anchor);
      send_op(KIND_SPARE,  anchor);
   endtask

   task automatic test_random_traffic();
      random_ops(300);
   endtask

   // No idling on either side
   task automatic test_back_to_back();
      calm = 1'b1;
      random_ops(60);
      calm = 1'b0;
   endtask

   task automatic test_pause_mid_stream();
      random_ops(20);
      wait_drained();
      random_ops(20);
   endtask

   // Receiver: hold off for a random stall, none while calm is set, before taking each response beat
   initial begin
      int stall;
      @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, IDLE_MAX);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Compare every response beat with the oldest outstanding prediction
   always @(posedge clock) begin
      member_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (results_due.size() == 0) begin
            failures++;
            if (failures <= FAIL_REPORTS)
               $display("%0t: response beat with nothing outstanding, tdata=%02h",
                        $realtime, rsp_tdata);
         end else begin
            want = results_due.pop_front();
            if (rsp_tdata[0] !== want.found || rsp_tdata[1] !== want.overflow ||
                rsp_tdata[7:2] !== '0) begin
               failures++;
               if (failures <= FAIL_REPORTS)
                  $display("%0t: mismatch, expected found=%0b overflow=%0b, got tdata=%02h",
                           $realtime, want.found, want.overflow, rsp_tdata);
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_drained();
      build_key_pool();
      test_random_traffic();
      wait_drained();
      test_back_to_back();
      wait_drained();
      test_pause_mid_stream();
      wait_drained();
      repeat (16) @(posedge clock);
      if (failures == 0 && results_due.size() == 0) begin
         $display("hash_set_membership verification clean");
      end else begin
         $display("hash_set_membership verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/hsm_pkg.sv
hw/rtl/hsm_ram.sv
hw/rtl/hsm_ctrl.sv
hw/rtl/hsm_dp.sv
hw/rtl/hash_set_membership.sv
verif/testbench.sv
